// File: hdl/segment_deframer_checker_defines.svh
// Assertion macros for the segment deframer/checker.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SEGMENT_DEFRAMER_CHECKER_DEFINES_SVH
`define SEGMENT_DEFRAMER_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdc check failed (same cycle)");
`define SDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdc check failed (next cycle)");
`else
`define SDC_ASSERT_IMPL(lbl, ante, cons)
`define SDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/sdc_pkg.sv
// Shared constants and types for the segment deframer/checker.
// No dependencies; used by the channel interfaces and all modules.
package sdc_pkg;

  localparam int HEADER_BYTES    = 24;
  localparam int LENGTH_OFFSET   = 16;
  localparam int CHECKSUM_OFFSET = 22;
  localparam int MAX_PAYLOAD     = 1024;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 11;
  localparam int LEN_W  = 16;
  localparam int SUM_W  = 16;

  localparam int CNT_MIN_W = $clog2(HEADER_BYTES + MAX_PAYLOAD + 1);
  localparam int CNT_W     = (CNT_MIN_W > IDX_W) ? CNT_MIN_W : IDX_W;
  localparam int TOT_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [SUM_W-1:0]  MASK16  = 16'hffff;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_BAD_SUM    = 2'd1,
    ST_OVER_LIMIT = 2'd2
  } status_t;

  // One classified transaction handed from front to back.
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic [BYTE_W-1:0]  sum_data;    // byte as seen by the checksum
    logic [CNT_W-1:0]   pos;
    logic               finish;      // last summed byte of the segment
    logic               over_limit;
    logic [LEN_W-1:0]   length;
    logic [SUM_W-1:0]   stored_sum;
  } q_entry_t;

endpackage

// File: hdl/sdc_in_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on sdc_pkg.
interface sdc_in_if;
  logic                       valid;
  logic                       ready;
  logic [sdc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sdc_out_if.sv
// Result channel: valid/ready handshake carrying byte and status items.
// Depends on sdc_pkg.
interface sdc_out_if;
  logic                       valid;
  logic                       ready;
  logic [sdc_pkg::BYTE_W-1:0] out_byte;
  logic [sdc_pkg::IDX_W-1:0]  byte_index;
  logic [1:0]                 item_kind;
  logic [1:0]                 status;
  logic [sdc_pkg::LEN_W-1:0]  seg_length;
  logic                       last;

  modport source (output valid, output out_byte, output byte_index, output item_kind,
                  output status, output seg_length, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_index, input item_kind,
                  input status, input seg_length, input last, output ready);
endinterface

// File: hdl/segment_deframer_checker.sv
// Segment deframer/checker, top level: front end, transaction queue, back end.
// A header or payload byte accepted on in_ch is written into the queue, then popped into
//   the output register that drives out_ch; the status item after '#' alike.
// Throughput: one byte per cycle unless the queue is full; the two-entry queue and the
//   output register absorb result-side stalls; in_ch.ready drops only when it is full.
// Reset (rst_n low, synchronous): start-pair hunt, queue empty, no result pending.
`include "segment_deframer_checker_defines.svh"

module segment_deframer_checker (
  input  logic             clk,
  input  logic             rst_n,
  sdc_in_if.sink           in_ch,
  sdc_out_if.source        out_ch
);

  logic              in_fire;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_valid;
  sdc_pkg::q_entry_t q_in;
  sdc_pkg::q_entry_t q_head;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  sdc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_ch.rx_byte),
    .push    (q_push),
    .entry   (q_in)
  );

  sdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .byte_index (out_ch.byte_index),
    .item_kind  (out_ch.item_kind),
    .status     (out_ch.status),
    .seg_length (out_ch.seg_length),
    .last       (out_ch.last)
  );

  `SDC_ASSERT_NEXT(a_full_holds_ready_low, q_full && !q_pop, !in_ch.ready)
  `SDC_ASSERT_IMPL(a_over_limit_len,
                   out_ch.valid && (out_ch.status == sdc_pkg::ST_OVER_LIMIT),
                   out_ch.seg_length > sdc_pkg::LEN_W'(sdc_pkg::MAX_PAYLOAD))
  `SDC_ASSERT_IMPL(a_last_only_status,
                   out_ch.valid && out_ch.last,
                   (out_ch.item_kind == sdc_pkg::KIND_STATUS) && (out_ch.out_byte == '0))

endmodule

// File: hdl/sdc_front.sv
// Framing front end: start/end pair hunt, header field capture, byte classing.
// Depends on sdc_pkg; pushes q_entry_t transactions into sdc_queue.
module sdc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [sdc_pkg::BYTE_W-1:0] in_byte,
  output logic                       push,
  output sdc_pkg::q_entry_t          entry
);

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_HEADER,
    PH_PAYLOAD,
    PH_END0,
    PH_END1
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [sdc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [sdc_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [sdc_pkg::SUM_W-1:0]   chk_r, chk_nxt;
  logic [sdc_pkg::CNT_W-1:0]   count_inc;
  logic [sdc_pkg::TOT_W-1:0]   seg_end;
  logic                        len_over;

  assign count_inc = count_r + sdc_pkg::CNT_W'(1);
  assign seg_end   = sdc_pkg::TOT_W'(sdc_pkg::HEADER_BYTES) + sdc_pkg::TOT_W'(len_r);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    chk_nxt   = chk_r;
    len_over  = 1'b0;
    push      = 1'b0;
    entry     = '0;
    entry.pos = count_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT0: begin
          if (in_byte == sdc_pkg::CH_BANG) phase_nxt = PH_HUNT1;
        end
        PH_HUNT1: begin
          if (in_byte == sdc_pkg::CH_AMP) begin
            phase_nxt = PH_HEADER;
            count_nxt = '0;
            len_nxt   = '0;
            chk_nxt   = '0;
          end else if (in_byte != sdc_pkg::CH_BANG) begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_HEADER: begin
          entry.kind     = sdc_pkg::KIND_HEADER;
          entry.data     = in_byte;
          entry.sum_data = in_byte;
          if (count_r == sdc_pkg::CNT_W'(sdc_pkg::LENGTH_OFFSET))
            len_nxt[7:0] = in_byte;
          if (count_r == sdc_pkg::CNT_W'(sdc_pkg::LENGTH_OFFSET + 1))
            len_nxt[15:8] = in_byte;
          if (count_r == sdc_pkg::CNT_W'(sdc_pkg::CHECKSUM_OFFSET)) begin
            chk_nxt[7:0]   = in_byte;
            entry.sum_data = '0;
          end
          if (count_r == sdc_pkg::CNT_W'(sdc_pkg::CHECKSUM_OFFSET + 1)) begin
            chk_nxt[15:8]  = in_byte;
            entry.sum_data = '0;
          end
          push      = 1'b1;
          count_nxt = count_inc;
          len_over  = (sdc_pkg::TOT_W'(len_nxt) > sdc_pkg::TOT_W'(sdc_pkg::MAX_PAYLOAD));
          if (count_r == sdc_pkg::CNT_W'(sdc_pkg::HEADER_BYTES - 1)) begin
            if (len_over || (len_nxt == '0)) begin
              phase_nxt = PH_END0;
              // over-limit segments never close the sum; status ignores it
              entry.finish = !len_over;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          entry.kind     = sdc_pkg::KIND_PAYLOAD;
          entry.data     = in_byte;
          entry.sum_data = in_byte;
          push           = 1'b1;
          count_nxt      = count_inc;
          if (sdc_pkg::TOT_W'(count_inc) >= seg_end) begin
            entry.finish = 1'b1;
            phase_nxt    = PH_END0;
          end
        end
        PH_END0: begin
          if (in_byte == sdc_pkg::CH_BANG) phase_nxt = PH_END1;
        end
        PH_END1: begin
          if (in_byte == sdc_pkg::CH_HASH) begin
            entry.kind       = sdc_pkg::KIND_STATUS;
            entry.over_limit = (sdc_pkg::TOT_W'(len_r) > sdc_pkg::TOT_W'(sdc_pkg::MAX_PAYLOAD));
            entry.length     = len_r;
            entry.stored_sum = chk_r;
            push             = 1'b1;
            phase_nxt        = PH_HUNT0;
          end else if (in_byte != sdc_pkg::CH_BANG) begin
            phase_nxt = PH_END0;
          end
        end
        default: phase_nxt = PH_HUNT0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      count_r <= '0;
      len_r   <= '0;
      chk_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      chk_r   <= chk_nxt;
    end
  end

endmodule

// File: hdl/sdc_queue.sv
// Short FIFO of classified transactions between front and back.
// Depends on sdc_pkg (entry type and depth).
module sdc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdc_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output sdc_pkg::q_entry_t head
);

  sdc_pkg::q_entry_t            mem_r [sdc_pkg::QUEUE_DEPTH];
  logic [sdc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sdc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sdc_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full       = (count_r == sdc_pkg::QCNT_W'(sdc_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == sdc_pkg::QPTR_W'(sdc_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + sdc_pkg::QPTR_W'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == sdc_pkg::QPTR_W'(sdc_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + sdc_pkg::QPTR_W'(1);
    if (do_push && !do_pop)
      count_nxt = count_r + sdc_pkg::QCNT_W'(1);
    else if (do_pop && !do_push)
      count_nxt = count_r - sdc_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// File: hdl/sdc_back.sv
// Back end: ones'-complement checksum accumulation and registered result stage.
// Depends on sdc_pkg; pops q_entry_t transactions from sdc_queue.
module sdc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  sdc_pkg::q_entry_t          head,
  output logic                       pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [sdc_pkg::BYTE_W-1:0] out_byte,
  output logic [sdc_pkg::IDX_W-1:0]  byte_index,
  output logic [1:0]                 item_kind,
  output logic [1:0]                 status,
  output logic [sdc_pkg::LEN_W-1:0]  seg_length,
  output logic                       last
);

  logic [sdc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [sdc_pkg::BYTE_W-1:0] pend_r, pend_nxt;
  logic                       valid_r;
  logic [sdc_pkg::BYTE_W-1:0] byte_r;
  logic [sdc_pkg::IDX_W-1:0]  idx_r;
  logic [1:0]                 kind_r;
  logic [1:0]                 status_r;
  logic [sdc_pkg::LEN_W-1:0]  len_r;
  logic                       last_r;
  logic [sdc_pkg::SUM_W-1:0]  sum_base;
  logic [sdc_pkg::SUM_W-1:0]  add_word;
  logic                       do_add;
  logic                       is_status;
  sdc_pkg::status_t           st;

  function automatic logic [sdc_pkg::SUM_W-1:0] ones_add(
    input logic [sdc_pkg::SUM_W-1:0] a,
    input logic [sdc_pkg::SUM_W-1:0] b
  );
    logic [sdc_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    // end-around carry; cannot carry again
    return s[sdc_pkg::SUM_W-1:0] + sdc_pkg::SUM_W'(s[sdc_pkg::SUM_W]);
  endfunction

  assign pop       = head_valid && (!valid_r || out_ready);
  assign is_status = (head.kind == sdc_pkg::KIND_STATUS);

  // first header byte of a segment restarts the sum
  assign sum_base = ((head.kind == sdc_pkg::KIND_HEADER) && (head.pos == '0)) ? '0 : sum_r;
  assign add_word = head.pos[0] ? {head.sum_data, pend_r} : {8'h00, head.sum_data};
  assign do_add   = head.pos[0] || head.finish;

  always_comb begin
    sum_nxt  = sum_r;
    pend_nxt = pend_r;
    if (pop && !is_status) begin
      if (!head.pos[0]) pend_nxt = head.sum_data;
      sum_nxt = do_add ? ones_add(sum_base, add_word) : sum_base;
    end
  end

  always_comb begin
    priority if (head.over_limit)                  st = sdc_pkg::ST_OVER_LIMIT;
    else if ((~sum_r & sdc_pkg::MASK16) == head.stored_sum) st = sdc_pkg::ST_GOOD;
    else                                           st = sdc_pkg::ST_BAD_SUM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sum_r   <= '0;
      pend_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      if (pop)
        valid_r <= 1'b1;
      else if (out_ready)
        valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r   <= head.data;
      idx_r    <= head.pos[sdc_pkg::IDX_W-1:0];
      kind_r   <= head.kind;
      status_r <= is_status ? st : sdc_pkg::ST_GOOD;
      len_r    <= is_status ? head.length : '0;
      last_r   <= is_status;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign byte_index = idx_r;
  assign item_kind  = kind_r;
  assign status     = status_r;
  assign seg_length = len_r;
  assign last       = last_r;

endmodule

// File: test/segment_deframer_checker_tb.sv
// Self-checking testbench for segment_deframer_checker: byte-stream framing and checksum status.
// Depends on sdc_pkg, sdc_in_if and sdc_out_if; the input is driven and results are
// checked against a cycle-free model of the deframer.
`timescale 1ns / 100ps

module segment_deframer_checker_tb;

  localparam int HOLD_CYCLES = 200;

  typedef enum logic [2:0] {
    HUNT_BANG,
    HUNT_AMP,
    TAKE_HEADER,
    TAKE_PAYLOAD,
    END_BANG,
    END_HASH
  } deframe_t;

  typedef struct packed {
    logic [sdc_pkg::BYTE_W-1:0] data;
    logic [sdc_pkg::IDX_W-1:0]  idx;
    sdc_pkg::kind_t             kind;
    sdc_pkg::status_t           st;
    logic [sdc_pkg::LEN_W-1:0]  len;
    logic                       last;
  } seg_result_t;

  logic clk;
  logic rst_n;

  sdc_in_if  in_ch();
  sdc_out_if out_ch();

  segment_deframer_checker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [sdc_pkg::BYTE_W-1:0] rx_bytes_q [$];
  seg_result_t                results_due_q [$];

  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_go   = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  int n_errors  = 0;
  int n_bytes   = 0;
  int n_checked = 0;
  int n_good    = 0;
  int n_bad_sum = 0;
  int n_over    = 0;

  // deframer shadow state
  deframe_t                   frm_state = HUNT_BANG;
  int unsigned                frm_count = 0;
  logic [sdc_pkg::LEN_W-1:0]  frm_len   = '0;
  int unsigned                frm_sum   = 0;
  logic [sdc_pkg::BYTE_W-1:0] frm_low   = '0;
  logic [sdc_pkg::SUM_W-1:0]  frm_chk   = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- checksum shadow ----------------
  function void sum_add(input logic [15:0] w);
    frm_sum = frm_sum + 32'(w);
    frm_sum = (frm_sum >> 16) + (frm_sum & 32'hffff);
  endfunction

  function void sum_take(input int unsigned pos, input logic [7:0] b);
    if (pos[0] == 1'b0) frm_low = b;
    else sum_add({b, frm_low});
  endfunction

  // odd total: last byte padded with zero
  function void sum_pad();
    if (frm_count[0]) sum_add({8'h00, frm_low});
  endfunction

  function void deframe_byte(input logic [7:0] b);
    seg_result_t r;
    logic [7:0]  cb;
    logic [15:0] folded;
    r = '0;
    case (frm_state)
      HUNT_BANG: begin
        if (b == sdc_pkg::CH_BANG) frm_state = HUNT_AMP;
      end
      HUNT_AMP: begin
        if (b == sdc_pkg::CH_AMP) begin
          frm_state = TAKE_HEADER;
          frm_count = 0;
          frm_len = '0;
          frm_sum = 0;
          frm_low = '0;
          frm_chk = '0;
        end else if (b != sdc_pkg::CH_BANG) begin
          frm_state = HUNT_BANG;
        end
      end
      TAKE_HEADER: begin
        cb = b;
        if (frm_count == sdc_pkg::LENGTH_OFFSET) frm_len[7:0] = b;
        if (frm_count == sdc_pkg::LENGTH_OFFSET + 1) frm_len[15:8] = b;
        if (frm_count == sdc_pkg::CHECKSUM_OFFSET) begin
          frm_chk[7:0] = b;
          cb = 8'h00;
        end
        if (frm_count == sdc_pkg::CHECKSUM_OFFSET + 1) begin
          frm_chk[15:8] = b;
          cb = 8'h00;
        end
        sum_take(frm_count, cb);
        r.data = b;
        r.idx = frm_count[sdc_pkg::IDX_W-1:0];
        r.kind = sdc_pkg::KIND_HEADER;
        r.st = sdc_pkg::ST_GOOD;
        results_due_q.push_back(r);
        frm_count++;
        if (frm_count >= sdc_pkg::HEADER_BYTES) begin
          if (frm_len > sdc_pkg::MAX_PAYLOAD) begin
            frm_state = END_BANG;
          end else if (frm_len == 0) begin
            sum_pad();
            frm_state = END_BANG;
          end else begin
            frm_state = TAKE_PAYLOAD;
          end
        end
      end
      TAKE_PAYLOAD: begin
        sum_take(frm_count, b);
        r.data = b;
        r.idx = frm_count[sdc_pkg::IDX_W-1:0];
        r.kind = sdc_pkg::KIND_PAYLOAD;
        r.st = sdc_pkg::ST_GOOD;
        results_due_q.push_back(r);
        frm_count++;
        if (frm_count >= sdc_pkg::HEADER_BYTES + frm_len) begin
          sum_pad();
          frm_state = END_BANG;
        end
      end
      END_BANG: begin
        if (b == sdc_pkg::CH_BANG) frm_state = END_HASH;
      end
      END_HASH: begin
        if (b == sdc_pkg::CH_HASH) begin
          folded = frm_sum[15:0];
          if (frm_len > sdc_pkg::MAX_PAYLOAD) r.st = sdc_pkg::ST_OVER_LIMIT;
          else if (~folded == frm_chk) r.st = sdc_pkg::ST_GOOD;
          else r.st = sdc_pkg::ST_BAD_SUM;
          r.data = '0;
          r.idx = frm_count[sdc_pkg::IDX_W-1:0];
          r.kind = sdc_pkg::KIND_STATUS;
          r.len = frm_len;
          r.last = 1'b1;
          results_due_q.push_back(r);
          frm_state = HUNT_BANG;
        end else if (b != sdc_pkg::CH_BANG) begin
          frm_state = END_BANG;
        end
      end
      default: frm_state = HUNT_BANG;
    endcase
  endfunction

  function void check_field(input string name, input logic [15:0] exp_v,
                            input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= rx_bytes_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver, with one long hold-off ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------- monitor ----------------
  // input transaction predicted before the output one is checked, in one process
  always @(posedge clk) begin
    seg_result_t e;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (results_due_q.size() == 0) begin
          $error("unexpected result: byte %0h index %0d kind %0d", out_ch.out_byte,
                 out_ch.byte_index, out_ch.item_kind);
          n_errors++;
        end else begin
          e = results_due_q.pop_front();
          n_checked++;
          check_field("out_byte", e.data, out_ch.out_byte);
          check_field("byte_index", e.idx, out_ch.byte_index);
          check_field("item_kind", e.kind, out_ch.item_kind);
          check_field("status", e.st, out_ch.status);
          check_field("seg_length", e.len, out_ch.seg_length);
          check_field("last", e.last, out_ch.last);
          if (e.kind == sdc_pkg::KIND_STATUS) begin
            case (e.st)
              sdc_pkg::ST_GOOD:       n_good++;
              sdc_pkg::ST_BAD_SUM:    n_bad_sum++;
              sdc_pkg::ST_OVER_LIMIT: n_over++;
              default: ;
            endcase
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    n_bytes++;
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    logic [7:0] b;
    case (fill)
      1: b = 8'h00;
      2: b = 8'hff;
      3: begin
        case ($urandom_range(2))
          0: b = sdc_pkg::CH_BANG;
          1: b = sdc_pkg::CH_AMP;
          default: b = sdc_pkg::CH_HASH;
        endcase
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // fill: 0 random, 1 zeros, 2 ones, 3 delimiter characters
  // end_mode: 0 clean close, 1 noise before close, 2 broken close pair first
  task automatic add_segment(input int len_field, input bit bad_sum, input int fill,
                             input int end_mode);
    logic [7:0]  seg [$];
    logic [7:0]  nb;
    logic [15:0] csum;
    int unsigned acc;
    int          n_pay;
    int          i;
    int          k;
    for (i = 0; i < sdc_pkg::HEADER_BYTES; i++) seg.push_back(fill_byte(fill));
    seg[sdc_pkg::LENGTH_OFFSET] = len_field[7:0];
    seg[sdc_pkg::LENGTH_OFFSET+1] = len_field[15:8];
    seg[sdc_pkg::CHECKSUM_OFFSET] = 8'h00;
    seg[sdc_pkg::CHECKSUM_OFFSET+1] = 8'h00;
    n_pay = (len_field > sdc_pkg::MAX_PAYLOAD) ? 0 : len_field;
    for (i = 0; i < n_pay; i++) seg.push_back(fill_byte(fill));
    acc = 0;
    for (i = 0; i < seg.size(); i += 2) begin
      acc = acc + 32'({((i + 1 < seg.size()) ? seg[i+1] : 8'h00), seg[i]});
      acc = (acc >> 16) + (acc & 32'hffff);
    end
    csum = ~acc[15:0];
    if (bad_sum) csum = csum ^ (16'h1 << $urandom_range(15));
    seg[sdc_pkg::CHECKSUM_OFFSET] = csum[7:0];
    seg[sdc_pkg::CHECKSUM_OFFSET+1] = csum[15:8];
    push_byte(sdc_pkg::CH_BANG);
    push_byte(sdc_pkg::CH_AMP);
    foreach (seg[j]) push_byte(seg[j]);
    if (end_mode == 1) begin
      k = $urandom_range(3);
      for (i = 0; i < k; i++) begin
        do nb = 8'($urandom_range(255)); while (nb == sdc_pkg::CH_BANG);
        push_byte(nb);
      end
    end else if (end_mode == 2) begin
      push_byte(sdc_pkg::CH_BANG);
      push_byte(8'h30);
      push_byte(sdc_pkg::CH_BANG);
    end
    push_byte(sdc_pkg::CH_BANG);
    push_byte(sdc_pkg::CH_HASH);
  endtask

  task automatic wait_drain();
    while (rx_bytes_q.size() != 0 || in_ch.valid || results_due_q.size() != 0)
      @(negedge clk);
  endtask

  // mostly well-formed segments with random content, some noise and bad sums
  task automatic run_random(input int budget);
    int start;
    int r;
    int len;
    int k;
    int i;
    start = n_bytes;
    while (n_bytes - start < budget) begin
      r = $urandom_range(99);
      if (r < 10) begin
        k = $urandom_range(6, 1);
        for (i = 0; i < k; i++) push_byte(8'($urandom_range(255)));
      end else begin
        r = $urandom_range(99);
        if (r < 5) len = $urandom_range(65535, sdc_pkg::MAX_PAYLOAD + 1);
        else if (r < 20) len = $urandom_range(80, 13);
        else len = $urandom_range(12, 0);
        add_segment(len, ($urandom_range(99) < 12),
                    ($urandom_range(99) < 85) ? 0 : $urandom_range(3, 1),
                    $urandom_range(2));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: stray bytes, broken and repeated start pair, then the special segments
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(sdc_pkg::CH_BANG);
    push_byte(8'h41);
    push_byte(sdc_pkg::CH_BANG);
    push_byte(sdc_pkg::CH_BANG);
    add_segment(0, 1'b0, 0, 0);
    add_segment(1, 1'b0, 0, 1);
    add_segment(2, 1'b0, 1, 0);
    add_segment(3, 1'b0, 2, 0);
    add_segment(5, 1'b1, 0, 2);
    add_segment(7, 1'b0, 3, 0);
    add_segment(sdc_pkg::MAX_PAYLOAD + 1, 1'b0, 0, 1);
    add_segment(16'hffff, 1'b0, 2, 0);
    wait_drain();

    // no idling, with the long receiver hold-off to back up the input
    run_random(60);
    hold_go = 1'b1;
    wait_drain();

    gap_pct = 47;
    stall_pct = 0;
    run_random(60);
    wait_drain();

    gap_pct = 0;
    stall_pct = 47;
    run_random(60);
    wait_drain();

    gap_pct = 38;
    stall_pct = 38;
    run_random(60);
    wait_drain();

    repeat (20) @(negedge clk);
    $display("Covered %0d input bytes under four idle/stall mixes, %0d results checked.",
             n_bytes, n_checked);
    $display("Segment status seen: %0d good, %0d bad checksum, %0d over limit.",
             n_good, n_bad_sum, n_over);
    if (n_errors == 0 && results_due_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/sdc_pkg.sv
hdl/sdc_in_if.sv
hdl/sdc_out_if.sv
hdl/sdc_front.sv
hdl/sdc_queue.sv
hdl/sdc_back.sv
hdl/segment_deframer_checker.sv
test/segment_deframer_checker_tb.sv
